FILE: rtl/wiit_pkg.sv
// shared types and constants for the world inverse inertia tensor block
`timescale 1ns / 1ps
package wiit_pkg;

  localparam int AXIS_W   = 16;  // signed Q1.15 axis component
  localparam int INV_W    = 32;  // unsigned Q16.16 inverse inertia
  localparam int PROD_W   = 32;  // axis times axis, Q2.30
  localparam int TERM_W   = 63;  // axis product times inertia, Q17.46
  localparam int SUM_W    = 65;  // three terms, Q19.46
  localparam int OUT_W    = 36;  // signed Q20.16 result
  localparam int FRAC_SHR = 30;  // Q.46 down to Q.16
  localparam int N_AXES   = 3;
  localparam int N_LANES  = 6;

  typedef enum logic [1:0] {
    COL_X = 2'd0,
    COL_Y = 2'd1,
    COL_Z = 2'd2
  } wiit_col_e;

  // lane order xx, xy, xz, yy, yz, zz
  localparam wiit_col_e LANE_I [N_LANES] = '{COL_X, COL_X, COL_X, COL_Y, COL_Y, COL_Z};
  localparam wiit_col_e LANE_J [N_LANES] = '{COL_X, COL_Y, COL_Z, COL_Y, COL_Z, COL_Z};

  typedef struct packed {
    logic prod_en;
    logic scale_en;
    logic sum_en;
    logic out_en;
  } wiit_en_t;

endpackage

FILE: rtl/world_inverse_inertia_tensor.sv
// World inverse inertia tensor R^T diag(invI) R for one rigid body per beat.
// Takes one beat every clock cycle when the output is not stalled and passes
// it through registered stages: six lanes, one per distinct tensor entry,
// each run an axis-product multiplier stage, a 32x33 inertia-scaling
// multiplier stage and a three-term adder stage; a shared output stage rounds
// to nearest (ties up) and saturates to signed Q20.16. Empty stages fill
// while the output is stalled, so up to four beats are held in flight.
`timescale 1ns / 1ps
module world_inverse_inertia_tensor
  import wiit_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [AXIS_W-1:0] front_x_i,
  input  logic signed [AXIS_W-1:0] front_y_i,
  input  logic signed [AXIS_W-1:0] front_z_i,
  input  logic signed [AXIS_W-1:0] up_x_i,
  input  logic signed [AXIS_W-1:0] up_y_i,
  input  logic signed [AXIS_W-1:0] up_z_i,
  input  logic signed [AXIS_W-1:0] side_x_i,
  input  logic signed [AXIS_W-1:0] side_y_i,
  input  logic signed [AXIS_W-1:0] side_z_i,
  input  logic        [INV_W-1:0]  inv_inertia_a_i,
  input  logic        [INV_W-1:0]  inv_inertia_b_i,
  input  logic        [INV_W-1:0]  inv_inertia_c_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] tensor_xx_o,
  output logic signed [OUT_W-1:0] tensor_xy_o,
  output logic signed [OUT_W-1:0] tensor_xz_o,
  output logic signed [OUT_W-1:0] tensor_yy_o,
  output logic signed [OUT_W-1:0] tensor_yz_o,
  output logic signed [OUT_W-1:0] tensor_zz_o
);

  wiit_en_t en;

  // col[c][k]: component c of axis row k (front, up, side)
  logic signed [AXIS_W-1:0] col [N_AXES][N_AXES];
  logic        [INV_W-1:0]  inv [N_AXES];
  logic signed [SUM_W-1:0]  sum [N_LANES];
  logic signed [OUT_W-1:0]  tensor [N_LANES];

  assign col[COL_X] = '{front_x_i, up_x_i, side_x_i};
  assign col[COL_Y] = '{front_y_i, up_y_i, side_y_i};
  assign col[COL_Z] = '{front_z_i, up_z_i, side_z_i};
  assign inv        = '{inv_inertia_a_i, inv_inertia_b_i, inv_inertia_c_i};

  wiit_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .en_o        (en)
  );

  for (genvar l = 0; l < N_LANES; l++) begin : g_lane
    wiit_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .ai_i  (col[LANE_I[l]]),
      .aj_i  (col[LANE_J[l]]),
      .inv_i (inv),
      .sum_o (sum[l])
    );
  end

  wiit_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (en),
    .sum_i    (sum),
    .tensor_o (tensor)
  );

  assign tensor_xx_o = tensor[0];
  assign tensor_xy_o = tensor[1];
  assign tensor_xz_o = tensor[2];
  assign tensor_yy_o = tensor[3];
  assign tensor_yz_o = tensor[4];
  assign tensor_zz_o = tensor[5];

endmodule

FILE: rtl/wiit_ctl.sv
// pipeline valid tracking and per-stage load enables
`timescale 1ns / 1ps
module wiit_ctl
  import wiit_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output wiit_en_t en_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;

  // a stage may load when empty or when its content moves on
  assign adv4 = !v4_q || !out_stall_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_stall_o  = !adv1;
  assign out_valid_o = v4_q;

  assign en_o.prod_en  = adv1;
  assign en_o.scale_en = adv2;
  assign en_o.sum_en   = adv3;
  assign en_o.out_en   = adv4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

endmodule

FILE: rtl/wiit_lane.sv
// one tensor entry: axis products, inertia scaling and three-term sum
`timescale 1ns / 1ps
module wiit_lane
  import wiit_pkg::*;
(
  input  logic                    clk_i,
  input  wiit_en_t                en_i,
  input  logic signed [AXIS_W-1:0] ai_i [N_AXES],
  input  logic signed [AXIS_W-1:0] aj_i [N_AXES],
  input  logic        [INV_W-1:0]  inv_i [N_AXES],
  output logic signed [SUM_W-1:0]  sum_o
);

  logic signed [PROD_W-1:0] p_d   [N_AXES];
  logic signed [PROD_W-1:0] p_q   [N_AXES];
  logic        [INV_W-1:0]  inv_q [N_AXES];
  logic signed [TERM_W-1:0] m_d   [N_AXES];
  logic signed [TERM_W-1:0] m_q   [N_AXES];
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  sum_q;

  always_comb begin
    for (int k = 0; k < N_AXES; k++) begin
      p_d[k] = PROD_W'(ai_i[k] * aj_i[k]);
    end
  end

  // signed product times zero-extended inertia, fits in 63 bits
  always_comb begin
    logic signed [63:0] pe;
    logic signed [63:0] ie;
    for (int k = 0; k < N_AXES; k++) begin
      pe     = 64'(p_q[k]);
      ie     = $signed({32'd0, inv_q[k]});
      m_d[k] = TERM_W'(pe * ie);
    end
  end

  assign sum_d = SUM_W'(m_q[0]) + SUM_W'(m_q[1]) + SUM_W'(m_q[2]);

  always_ff @(posedge clk_i) begin
    if (en_i.prod_en) begin
      for (int k = 0; k < N_AXES; k++) begin
        p_q[k]   <= p_d[k];
        inv_q[k] <= inv_i[k];
      end
    end
    if (en_i.scale_en) begin
      for (int k = 0; k < N_AXES; k++) begin
        m_q[k] <= m_d[k];
      end
    end
    if (en_i.sum_en) sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

FILE: rtl/wiit_merge.sv
// rounds and saturates the lane sums into the shared output register
`timescale 1ns / 1ps
module wiit_merge
  import wiit_pkg::*;
(
  input  logic                    clk_i,
  input  wiit_en_t                en_i,
  input  logic signed [SUM_W-1:0] sum_i    [N_LANES],
  output logic signed [OUT_W-1:0] tensor_o [N_LANES]
);

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(64'd1 << (FRAC_SHR - 1));
  localparam logic signed [SUM_W-1:0] OUT_MAX  = SUM_W'((65'sd1 <<< (OUT_W - 1)) - 65'sd1);
  localparam logic signed [SUM_W-1:0] OUT_MIN  = -SUM_W'(65'sd1 <<< (OUT_W - 1));

  logic signed [OUT_W-1:0] res_d [N_LANES];
  logic signed [OUT_W-1:0] res_q [N_LANES];

  // nearest, ties toward plus infinity
  always_comb begin
    logic signed [SUM_W-1:0] rnd;
    logic signed [SUM_W-1:0] sh;
    for (int l = 0; l < N_LANES; l++) begin
      rnd = sum_i[l] + RND_HALF;
      sh  = rnd >>> FRAC_SHR;
      if (sh > OUT_MAX) begin
        res_d[l] = OUT_MAX[OUT_W-1:0];
      end else if (sh < OUT_MIN) begin
        res_d[l] = OUT_MIN[OUT_W-1:0];
      end else begin
        res_d[l] = sh[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.out_en) begin
      for (int l = 0; l < N_LANES; l++) begin
        res_q[l] <= res_d[l];
      end
    end
  end

  assign tensor_o = res_q;

endmodule

FILE: tb/wiit_tensor_checker.sv
// checker for the world inverse inertia tensor block: predicts each tensor and compares beats
`timescale 1ns / 1ps
module wiit_tensor_checker
  import wiit_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_o,
  input  logic signed [AXIS_W-1:0] front_x_i,
  input  logic signed [AXIS_W-1:0] front_y_i,
  input  logic signed [AXIS_W-1:0] front_z_i,
  input  logic signed [AXIS_W-1:0] up_x_i,
  input  logic signed [AXIS_W-1:0] up_y_i,
  input  logic signed [AXIS_W-1:0] up_z_i,
  input  logic signed [AXIS_W-1:0] side_x_i,
  input  logic signed [AXIS_W-1:0] side_y_i,
  input  logic signed [AXIS_W-1:0] side_z_i,
  input  logic        [INV_W-1:0]  inv_inertia_a_i,
  input  logic        [INV_W-1:0]  inv_inertia_b_i,
  input  logic        [INV_W-1:0]  inv_inertia_c_i,
  input  logic                     out_valid_o,
  input  logic                     out_stall_i,
  input  logic signed [OUT_W-1:0]  tensor_xx_o,
  input  logic signed [OUT_W-1:0]  tensor_xy_o,
  input  logic signed [OUT_W-1:0]  tensor_xz_o,
  input  logic signed [OUT_W-1:0]  tensor_yy_o,
  input  logic signed [OUT_W-1:0]  tensor_yz_o,
  input  logic signed [OUT_W-1:0]  tensor_zz_o,
  output int                       mismatches_o,
  output int                       pending_o
);

  localparam int WIDE_W = 72;
  localparam logic signed [WIDE_W-1:0] SAT_HI = (72'sd1 <<< (OUT_W-1)) - 72'sd1;
  localparam logic signed [WIDE_W-1:0] SAT_LO = -(72'sd1 <<< (OUT_W-1));
  localparam logic signed [WIDE_W-1:0] HALF_LSB = 72'sd1 <<< (FRAC_SHR-1);

  typedef struct packed {
    logic signed [OUT_W-1:0] xx;
    logic signed [OUT_W-1:0] xy;
    logic signed [OUT_W-1:0] xz;
    logic signed [OUT_W-1:0] yy;
    logic signed [OUT_W-1:0] yz;
    logic signed [OUT_W-1:0] zz;
  } tensor_t;

  tensor_t tensor_q[$];
  int      bad_fields = 0;

  // one entry: sum over the three axes of comp_i * comp_j * inertia, exact, then rounded
  function automatic logic signed [OUT_W-1:0] tensor_entry(
    input logic signed [AXIS_W-1:0] f_i, f_j, u_i, u_j, s_i, s_j,
    input logic        [INV_W-1:0]  inv_a, inv_b, inv_c
  );
    logic signed [WIDE_W-1:0] pa, pb, pc, acc;
    pa  = f_i * f_j;
    pb  = u_i * u_j;
    pc  = s_i * s_j;
    acc = pa * $signed({1'b0, inv_a}) + pb * $signed({1'b0, inv_b})
        + pc * $signed({1'b0, inv_c});
    // Q.46 to Q.16, nearest with ties going up
    acc = (acc + HALF_LSB) >>> FRAC_SHR;
    if (acc > SAT_HI) acc = SAT_HI;
    else if (acc < SAT_LO) acc = SAT_LO;
    return acc[OUT_W-1:0];
  endfunction

  function automatic tensor_t world_tensor();
    tensor_t t;
    t.xx = tensor_entry(front_x_i, front_x_i, up_x_i, up_x_i, side_x_i, side_x_i,
                        inv_inertia_a_i, inv_inertia_b_i, inv_inertia_c_i);
    t.xy = tensor_entry(front_x_i, front_y_i, up_x_i, up_y_i, side_x_i, side_y_i,
                        inv_inertia_a_i, inv_inertia_b_i, inv_inertia_c_i);
    t.xz = tensor_entry(front_x_i, front_z_i, up_x_i, up_z_i, side_x_i, side_z_i,
                        inv_inertia_a_i, inv_inertia_b_i, inv_inertia_c_i);
    t.yy = tensor_entry(front_y_i, front_y_i, up_y_i, up_y_i, side_y_i, side_y_i,
                        inv_inertia_a_i, inv_inertia_b_i, inv_inertia_c_i);
    t.yz = tensor_entry(front_y_i, front_z_i, up_y_i, up_z_i, side_y_i, side_z_i,
                        inv_inertia_a_i, inv_inertia_b_i, inv_inertia_c_i);
    t.zz = tensor_entry(front_z_i, front_z_i, up_z_i, up_z_i, side_z_i, side_z_i,
                        inv_inertia_a_i, inv_inertia_b_i, inv_inertia_c_i);
    return t;
  endfunction

  task automatic check_lane(input string lane, input logic signed [OUT_W-1:0] want, got);
    if (got !== want) begin
      if (bad_fields < 10)
        $display("%0t tensor_%s mismatch: expected %0d, got %0d", $time, lane, want, got);
      bad_fields++;
    end
  endtask

  always @(posedge clk_i) begin
    tensor_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tensor_q.push_back(world_tensor());
      if (out_valid_o && !out_stall_i) begin
        if (tensor_q.size() == 0) begin
          if (bad_fields < 10) $display("%0t tensor beat with nothing expected", $time);
          bad_fields++;
        end else begin
          want = tensor_q.pop_front();
          check_lane("xx", want.xx, tensor_xx_o);
          check_lane("xy", want.xy, tensor_xy_o);
          check_lane("xz", want.xz, tensor_xz_o);
          check_lane("yy", want.yy, tensor_yy_o);
          check_lane("yz", want.yz, tensor_yz_o);
          check_lane("zz", want.zz, tensor_zz_o);
        end
      end
    end
    mismatches_o <= bad_fields;
    pending_o    <= tensor_q.size();
  end

endmodule

FILE: tb/testbench.sv
// top of the world inverse inertia tensor regression: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
  import wiit_pkg::*;

  localparam logic signed [AXIS_W-1:0] AX_MIN = 16'h8000;
  localparam logic signed [AXIS_W-1:0] AX_MAX = 16'h7fff;
  localparam logic        [INV_W-1:0]  I_ONE  = 32'h0001_0000;
  localparam logic        [INV_W-1:0]  I_MAX  = 32'hffff_ffff;
  localparam logic        [INV_W-1:0]  TIE    = 32'h2000_0000;  // half of an output lsb
  localparam int N_RANDOM = 700;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     in_valid_i      = 1'b0;
  logic                     in_stall_o;
  logic signed [AXIS_W-1:0] front_x_i       = '0;
  logic signed [AXIS_W-1:0] front_y_i       = '0;
  logic signed [AXIS_W-1:0] front_z_i       = '0;
  logic signed [AXIS_W-1:0] up_x_i          = '0;
  logic signed [AXIS_W-1:0] up_y_i          = '0;
  logic signed [AXIS_W-1:0] up_z_i          = '0;
  logic signed [AXIS_W-1:0] side_x_i        = '0;
  logic signed [AXIS_W-1:0] side_y_i        = '0;
  logic signed [AXIS_W-1:0] side_z_i        = '0;
  logic        [INV_W-1:0]  inv_inertia_a_i = '0;
  logic        [INV_W-1:0]  inv_inertia_b_i = '0;
  logic        [INV_W-1:0]  inv_inertia_c_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i     = 1'b0;
  logic signed [OUT_W-1:0]  tensor_xx_o;
  logic signed [OUT_W-1:0]  tensor_xy_o;
  logic signed [OUT_W-1:0]  tensor_xz_o;
  logic signed [OUT_W-1:0]  tensor_yy_o;
  logic signed [OUT_W-1:0]  tensor_yz_o;
  logic signed [OUT_W-1:0]  tensor_zz_o;

  int bad_fields;
  int tensors_pending;

  // next body: axes in order front xyz, up xyz, side xyz, then inertias a, b, c
  logic signed [AXIS_W-1:0] axis_v  [9];
  logic        [INV_W-1:0]  inert_v [3];
  int                       burst_left = 0;

  always #5 clk_i = ~clk_i;

  world_inverse_inertia_tensor DUT (.*);

  wiit_tensor_checker checker_i (
    .*,
    .mismatches_o(bad_fields),
    .pending_o   (tensors_pending)
  );

  // offer one body beat and hold it until accepted; gaps fall between bursts
  task automatic drive_body();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    front_x_i       <= axis_v[0];
    front_y_i       <= axis_v[1];
    front_z_i       <= axis_v[2];
    up_x_i          <= axis_v[3];
    up_y_i          <= axis_v[4];
    up_z_i          <= axis_v[5];
    side_x_i        <= axis_v[6];
    side_y_i        <= axis_v[7];
    side_z_i        <= axis_v[8];
    inv_inertia_a_i <= inert_v[0];
    inv_inertia_b_i <= inert_v[1];
    inv_inertia_c_i <= inert_v[2];
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic signed [AXIS_W-1:0] corner_axis();
    case ($urandom_range(0, 5))
      0:       return AX_MIN;
      1:       return AX_MAX;
      2:       return '0;
      3:       return -1;
      4:       return 1;
      default: return AXIS_W'($urandom);
    endcase
  endfunction

  function automatic logic [INV_W-1:0] corner_inertia();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return I_MAX;
      2:       return 32'h8000_0000;
      3:       return TIE;
      default: return $urandom;
    endcase
  endfunction

  // receiver: random stall patterns, with one long hold-off early on to fill the pipe
  initial begin
    int mode;
    int run;
    do @(posedge clk_i); while (!rst_ni);
    repeat (200) begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
      @(posedge clk_i);
    end
    out_stall_i <= 1'b1;
    repeat (80) @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(20, 150);
      repeat (run) begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ~out_stall_i;
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int mode;
    int k;
    int j;
    int swap;
    int col [3];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners of the ranges
    axis_v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    inert_v = '{0, 0, 0};
    drive_body();
    axis_v = '{AX_MAX, 0, 0, 0, AX_MAX, 0, 0, 0, AX_MAX};
    inert_v = '{I_ONE, I_ONE, I_ONE};
    drive_body();
    inert_v = '{I_MAX, 32'h0, 32'h1};
    drive_body();
    axis_v = '{AX_MIN, AX_MIN, AX_MIN, AX_MIN, AX_MIN, AX_MIN, AX_MIN, AX_MIN, AX_MIN};
    inert_v = '{I_MAX, I_MAX, I_MAX};
    drive_body();
    inert_v = '{32'h1, 32'h1, 32'h1};
    drive_body();
    axis_v = '{AX_MAX, AX_MAX, AX_MAX, AX_MAX, AX_MAX, AX_MAX, AX_MAX, AX_MAX, AX_MAX};
    inert_v = '{I_MAX, I_MAX, I_MAX};
    drive_body();
    // most negative off-diagonals
    axis_v = '{AX_MIN, AX_MAX, AX_MIN, AX_MIN, AX_MAX, AX_MIN, AX_MIN, AX_MAX, AX_MIN};
    drive_body();
    axis_v = '{AX_MIN, AX_MIN, AX_MIN, AX_MAX, AX_MAX, AX_MAX, AX_MIN, AX_MAX, AX_MIN};
    inert_v = '{32'h8000_0000, 32'hffff_0000, 32'h0000_ffff};
    drive_body();

    // rounding: exact ties both signs, and one step either side
    axis_v = '{1, 1, 1, 0, 0, 0, 0, 0, 0};
    inert_v = '{TIE, 0, 0};
    drive_body();
    axis_v = '{1, -1, 0, 0, 0, 0, 0, 0, 0};
    drive_body();
    inert_v = '{TIE - 1, 0, 0};
    drive_body();
    inert_v = '{TIE + 1, 0, 0};
    drive_body();
    axis_v = '{1, -1, 1, -1, 1, 1, 1, 1, -1};
    inert_v = '{TIE, TIE + 1, TIE - 1};
    drive_body();

    // proper rotations: quarter turn about z, eighth turn about x
    axis_v = '{0, AX_MAX, 0, AX_MIN, 0, 0, 0, 0, AX_MAX};
    inert_v = '{I_ONE, 32'h0002_0000, 32'h0000_8000};
    drive_body();
    axis_v = '{AX_MAX, 0, 0, 0, 23170, 23170, 0, -23170, 23170};
    inert_v = '{32'h0003_0000, 32'h0000_4000, 32'h0123_4567};
    drive_body();

    // each axis term on its own
    axis_v = '{AX_MIN, AX_MAX, 1, 0, 0, 0, 0, 0, 0};
    inert_v = '{I_MAX, 0, 0};
    drive_body();
    axis_v = '{0, 0, 0, AX_MIN, AX_MAX, 1, 0, 0, 0};
    inert_v = '{0, I_MAX, 0};
    drive_body();
    axis_v = '{0, 0, 0, 0, 0, 0, AX_MIN, AX_MAX, 1};
    inert_v = '{0, 0, I_MAX};
    drive_body();

    // axes that are not orthonormal at all
    axis_v = '{16'h1234, 16'hedcb, 16'h5a5a, 16'ha5a5, 16'h0f0f, 16'hf0f0,
               16'h7001, 16'h8ffe, 16'h3c3c};
    inert_v = '{32'hdead_beef, 32'h0bad_f00d, 32'h7fff_ffff};
    drive_body();

    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 3);
      case (mode)
        0: begin
          foreach (axis_v[i]) axis_v[i] = AXIS_W'($urandom);
          foreach (inert_v[i]) inert_v[i] = $urandom;
        end
        1: begin
          foreach (axis_v[i]) axis_v[i] = corner_axis();
          foreach (inert_v[i]) inert_v[i] = corner_inertia();
        end
        2: begin
          // signed permutation matrix at full scale
          col = '{0, 1, 2};
          for (k = 2; k > 0; k--) begin
            j = $urandom_range(0, k);
            swap = col[k];
            col[k] = col[j];
            col[j] = swap;
          end
          for (k = 0; k < 3; k++)
            for (j = 0; j < 3; j++)
              axis_v[k*3+j] = (j != col[k]) ? '0 :
                              ($urandom_range(0, 1) ? AX_MAX : AX_MIN);
          foreach (inert_v[i]) inert_v[i] = $urandom >> $urandom_range(0, 24);
        end
        default: begin
          // small axes with inertias around half an lsb hit the rounding boundary
          foreach (axis_v[i]) axis_v[i] = AXIS_W'($urandom_range(0, 16) - 8);
          foreach (inert_v[i]) inert_v[i] = TIE + $urandom_range(0, 4) - 2;
        end
      endcase
      drive_body();
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tensors_pending != 0);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (bad_fields == 0 && tensors_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
